// ===== rtl/dsto_pkg.sv =====
package dsto_pkg;

  // DST rule selection, written through the mode register
  typedef enum logic [1:0] {
    DST_OFF    = 2'd0,
    DST_ALWAYS = 2'd1,
    DST_US     = 2'd2,
    DST_EU     = 2'd3
  } dsto_mode_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_ZONE = 1'b0,
    CFG_MODE = 1'b1
  } dsto_cfg_e;

  localparam int unsigned ZONE_W = 17;
  localparam int unsigned UTC_W  = 32;
  localparam int unsigned CFG_W  = 17;
  localparam int unsigned DAY_W  = 16;   // days since 1969-01-01
  localparam int unsigned SOD_W  = 17;   // second of day

  localparam logic [SOD_W-1:0] SEC_PER_DAY  = 17'd86400;
  localparam logic [SOD_W-1:0] SEC_PER_HOUR = 17'd3600;
  localparam logic [SOD_W-1:0] US_START_SOD = 17'd7200;

  // Seconds to days: 86400 = 2^7 * 675, then a reciprocal multiply by 1/675
  localparam int unsigned DAY_PRE_SHIFT = 7;
  localparam int unsigned DAY_ODD       = 675;
  localparam int unsigned DAY_RCP_SHIFT = 36;
  localparam logic [26:0] DAY_RCP =
    27'(((64'd1 << DAY_RCP_SHIFT) + DAY_ODD - 1) / DAY_ODD);

  // Days to years: (4t+3)/1461 by reciprocal multiply
  localparam int unsigned YEAR_DAYS4    = 1461;
  localparam int unsigned YEAR_RCP_SHIFT = 29;
  localparam logic [18:0] YEAR_RCP =
    19'(((64'd1 << YEAR_RCP_SHIFT) + YEAR_DAYS4 - 1) / YEAR_DAYS4);

  // Last real day before the missing 2100-02-29, counted from 1969-01-01
  localparam logic [DAY_W-1:0] FEB28_2100 = 16'd47905;
  // Year index (from 1969) of 2100, a common year at the leap position of the 4-year cycle
  localparam logic [7:0] YEAR_2100 = 8'd131;

  // Day number offset between the epoch and 1969-01-01, less the one day added in dsto_day
  localparam logic [DAY_W-1:0] DAY_BIAS = 16'd364;

  typedef struct packed {
    logic [DAY_W-1:0] day;   // days since 1969-01-01
    logic [SOD_W-1:0] sod;   // second of that day
    logic [17:0]      v4;    // 4*day + 3, leap-corrected for 2100
  } dsto_day_t;

  typedef struct packed {
    logic [DAY_W-1:0] day;
    logic [SOD_W-1:0] sod;
    logic [DAY_W-1:0] start_day;
    logic [DAY_W-1:0] end_day;
  } dsto_bnd_t;

endpackage

// ===== rtl/dsto_if.sv =====
interface dsto_req_if;
  import dsto_pkg::*;
  logic             valid;
  logic             ready;
  logic [UTC_W-1:0] utc_seconds;
  modport source (output valid, output utc_seconds, input ready);
  modport sink   (input valid, input utc_seconds, output ready);
endinterface

interface dsto_rsp_if;
  import dsto_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [ZONE_W-1:0] offset_seconds;
  logic                     dst_on;
  modport source (output valid, output offset_seconds, output dst_on, input ready);
  modport sink   (input valid, input offset_seconds, input dst_on, output ready);
endinterface

interface dsto_cfg_if;
  import dsto_pkg::*;
  logic             valid;
  logic             ready;
  logic             reg_index;
  logic [CFG_W-1:0] wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== rtl/dsto_day.sv =====
module dsto_day (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic [dsto_pkg::UTC_W-1:0]         utc_seconds_i,
  input  logic signed [dsto_pkg::ZONE_W-1:0] zone_i,
  input  dsto_pkg::dsto_mode_e               mode_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output dsto_pkg::dsto_day_t                day_o
);
  import dsto_pkg::*;

  logic        va_q, vb_q, vc_q;
  logic        rdy_a, rdy_b, rdy_c;
  logic [32:0] na_d, na_q;
  logic [32:0] nb_q;
  logic [16:0] qb_d, qb_q;
  logic [52:0] prod_b;
  logic [33:0] prod_c;
  logic [DAY_W-1:0] day_c;
  logic [DAY_W-1:0] adj_c;
  dsto_day_t   dc_d, dc_q;

  assign rdy_c   = !vc_q || ready_i;
  assign rdy_b   = !vb_q || rdy_c;
  assign rdy_a   = !va_q || rdy_b;
  assign ready_o = rdy_a;
  assign valid_o = vc_q;
  assign day_o   = dc_q;

  // Stage A: local seconds for the US rule, UTC otherwise, biased by one day
  always_comb begin
    if (mode_i == DST_US) begin
      na_d = {1'b0, utc_seconds_i} + {{(33-ZONE_W){zone_i[ZONE_W-1]}}, zone_i}
             + 33'(SEC_PER_DAY);
    end else begin
      na_d = {1'b0, utc_seconds_i} + 33'(SEC_PER_DAY);
    end
  end

  // Stage B: day index plus one
  assign prod_b = 53'(na_q[32:DAY_PRE_SHIFT]) * 53'(DAY_RCP);
  assign qb_d   = prod_b[52:DAY_RCP_SHIFT];

  // Stage C: second of day, day since 1969-01-01, year-cycle numerator
  always_comb begin
    prod_c   = 34'(qb_q) * 34'(SEC_PER_DAY);
    day_c    = DAY_W'(qb_q) + DAY_BIAS;
    adj_c    = (day_c > FEB28_2100) ? day_c + 16'd1 : day_c;
    dc_d.day = day_c;
    dc_d.sod = SOD_W'(34'(nb_q) - prod_c);
    dc_d.v4  = {adj_c, 2'b11};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && valid_i) na_q <= na_d;
    if (rdy_b && va_q) begin
      nb_q <= na_q;
      qb_q <= qb_d;
    end
    if (rdy_c && vb_q) dc_q <= dc_d;
  end

`ifndef SYNTH
  a_sod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc_q |-> (dc_q.sod < SEC_PER_DAY))
    else $error("second of day out of range");
`endif

endmodule

// ===== rtl/dsto_rule.sv =====
module dsto_rule (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  dsto_pkg::dsto_day_t  day_i,
  input  dsto_pkg::dsto_mode_e mode_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output dsto_pkg::dsto_bnd_t  bnd_o
);
  import dsto_pkg::*;

  logic        vd_q, ve_q, vf_q;
  logic        rdy_d, rdy_e, rdy_f;
  logic [36:0] prod_d;
  logic [7:0]  kd_d, kd_q;
  logic [DAY_W-1:0] td_q, te_q;
  logic [SOD_W-1:0] sd_q, se_q;
  logic [5:0]  lp_e;
  logic        leap_e;
  logic [DAY_W-1:0] mar1_d, mar1_q;
  logic [7:0]  wv_d, wv_q;
  logic [16:0] wq_f;
  logic [2:0]  w_f, lead_f;
  logic [3:0]  w2_f, w6_f;
  dsto_bnd_t   bf_d, bf_q;

  assign rdy_f   = !vf_q || ready_i;
  assign rdy_e   = !ve_q || rdy_f;
  assign rdy_d   = !vd_q || rdy_e;
  assign ready_o = rdy_d;
  assign valid_o = vf_q;
  assign bnd_o   = bf_q;

  // Stage D: year index from 1969
  assign prod_d = 37'(day_i.v4) * 37'(YEAR_RCP);
  assign kd_d   = prod_d[36:YEAR_RCP_SHIFT];

  // Stage E: March 1 of that year and its weekday sum
  always_comb begin
    lp_e   = kd_q[7:2] - ((kd_q > YEAR_2100) ? 6'd1 : 6'd0);
    leap_e = (kd_q[1:0] == 2'b11) && (kd_q != YEAR_2100);
    mar1_d = DAY_W'(16'd365 * DAY_W'(kd_q)) + DAY_W'(lp_e) + 16'd59 + DAY_W'(leap_e);
    wv_d   = kd_q + 8'(lp_e) + 8'(leap_e) + 8'd62;
  end

  // Stage F: weekday of March 1, then the rule's boundary days
  always_comb begin
    wq_f   = (17'(wv_q) * 17'd293) >> 11;
    w_f    = 3'(wv_q - 8'(wq_f * 17'd7));
    lead_f = (w_f == 3'd0) ? 3'd0 : 3'd7 - w_f;
    w2_f   = {1'b0, w_f} + 4'd2;
    if (w2_f >= 4'd7) w2_f = w2_f - 4'd7;
    w6_f   = {1'b0, w_f} + 4'd6;
    if (w6_f >= 4'd7) w6_f = w6_f - 4'd7;
    bf_d.day = te_q;
    bf_d.sod = se_q;
    if (mode_i == DST_US) begin
      bf_d.start_day = mar1_q + DAY_W'(lead_f) + 16'd7;
      bf_d.end_day   = mar1_q + DAY_W'(lead_f) + 16'd245;
    end else begin
      bf_d.start_day = mar1_q + 16'd30 - DAY_W'(w2_f);
      bf_d.end_day   = mar1_q + 16'd244 - DAY_W'(w6_f);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
    end else begin
      if (rdy_d) vd_q <= valid_i;
      if (rdy_e) ve_q <= vd_q;
      if (rdy_f) vf_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_d && valid_i) begin
      kd_q <= kd_d;
      td_q <= day_i.day;
      sd_q <= day_i.sod;
    end
    if (rdy_e && vd_q) begin
      mar1_q <= mar1_d;
      wv_q   <= wv_d;
      te_q   <= td_q;
      se_q   <= sd_q;
    end
    if (rdy_f && ve_q) bf_q <= bf_d;
  end

`ifndef SYNTH
  a_year_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vd_q |-> (kd_q <= 8'd138))
    else $error("year index out of range");
  a_bnd_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vf_q |-> (bf_q.start_day < bf_q.end_day))
    else $error("rule start not before rule end");
`endif

endmodule

// ===== rtl/dst_utc_offset_top.sv =====
// Channel  Modport  Handshake       Payload
// req_i    sink     valid / ready   utc_seconds [31:0]
// rsp_o    source   valid / ready   offset_seconds [16:0] signed, dst_on
// cfg_i    sink     valid / ready   reg_index (0 zone, 1 mode), wdata [16:0]
//
// Seven register stages: three in dsto_day, three in dsto_rule, one output register.
// One request per cycle while rsp_o accepts responses.
// Each stage holds while its successor is full and stalled; empty stages fill.
// Reset clears all valid bits and sets zone 0, mode off. No clearing pass.
// Configuration writes are taken every cycle (cfg_i.ready is always high).
module dst_utc_offset_top (
  input  logic clk_i,
  input  logic rst_ni,
  dsto_req_if.sink   req_i,
  dsto_rsp_if.source rsp_o,
  dsto_cfg_if.sink   cfg_i
);
  import dsto_pkg::*;

  logic signed [ZONE_W-1:0] zone_q;
  dsto_mode_e               mode_q;

  logic      day_valid, day_ready;
  dsto_day_t day_data;
  logic      bnd_valid, bnd_ready;
  dsto_bnd_t bnd_data;

  logic       after_start, before_end, on_d;
  logic [SOD_W-1:0] start_sod, end_sod;
  logic signed [ZONE_W:0] sum_d;
  logic [ZONE_W-1:0] off_d;

  logic             ov_q;
  logic [ZONE_W-1:0] off_q;
  logic             on_q;

  // Register file: writes are accepted at any time
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q <= '0;
      mode_q <= DST_OFF;
    end else if (cfg_i.valid) begin
      unique case (dsto_cfg_e'(cfg_i.reg_index))
        CFG_ZONE: zone_q <= signed'(cfg_i.wdata[ZONE_W-1:0]);
        CFG_MODE: mode_q <= dsto_mode_e'(cfg_i.wdata[1:0]);
        default:  ;
      endcase
    end
  end

  // Seconds to day index and second of day
  dsto_day u_day (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (req_i.valid),
    .ready_o       (req_i.ready),
    .utc_seconds_i (req_i.utc_seconds),
    .zone_i        (zone_q),
    .mode_i        (mode_q),
    .valid_o       (day_valid),
    .ready_i       (day_ready),
    .day_o         (day_data)
  );

  // Year, weekday and the rule's start and end days
  dsto_rule u_rule (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (day_valid),
    .ready_o (day_ready),
    .day_i   (day_data),
    .mode_i  (mode_q),
    .valid_o (bnd_valid),
    .ready_i (bnd_ready),
    .bnd_o   (bnd_data)
  );

  // Final stage: decide DST by mode (off, always, or the half-open window on (day, second)),
  // then add the DST hour with saturation at 65535
  always_comb begin
    start_sod = (mode_q == DST_US) ? US_START_SOD : SEC_PER_HOUR;
    end_sod   = SEC_PER_HOUR;
    after_start = (bnd_data.day > bnd_data.start_day) ||
                  ((bnd_data.day == bnd_data.start_day) && (bnd_data.sod >= start_sod));
    before_end  = (bnd_data.day < bnd_data.end_day) ||
                  ((bnd_data.day == bnd_data.end_day) && (bnd_data.sod < end_sod));
    unique case (mode_q)
      DST_OFF:    on_d = 1'b0;
      DST_ALWAYS: on_d = 1'b1;
      DST_US,
      DST_EU:     on_d = after_start && before_end;
      default:    on_d = 1'b0;
    endcase
    sum_d = {zone_q[ZONE_W-1], zone_q} + (on_d ? 18'sd3600 : 18'sd0);
    // Positive overflow of the 17-bit field: clamp
    if (!sum_d[ZONE_W] && sum_d[ZONE_W-1]) begin
      off_d = 17'h0FFFF;
    end else begin
      off_d = sum_d[ZONE_W-1:0];
    end
  end

  assign bnd_ready = !ov_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (bnd_ready) begin
      ov_q <= bnd_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bnd_ready && bnd_valid) begin
      off_q <= off_d;
      on_q  <= on_d;
    end
  end

  assign rsp_o.valid          = ov_q;
  assign rsp_o.offset_seconds = signed'(off_q);
  assign rsp_o.dst_on         = on_q;

`ifndef SYNTH
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ov_q |-> req_i.ready)
    else $error("request stalled with empty output register");
`endif

endmodule

// ===== tb/dst_utc_offset_top_test.sv =====
`timescale 1ns / 100ps

module dst_utc_offset_top_test;
  import dsto_pkg::*;

  // Hard stop; a correct run needs a small fraction of this
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 75;
  localparam int unsigned IDLE_PCT = 29;
  localparam int unsigned TAIL_CYCLES = 21;

  typedef enum logic {
    ROW_CFG,
    ROW_REQ
  } row_kind_e;

  // One response: local offset and daylight-saving flag
  typedef struct {
    logic signed [ZONE_W-1:0] offset_seconds;
    logic                     dst_on;
  } local_offset_t;

  typedef struct {
    row_kind_e        kind;
    dsto_cfg_e        reg_sel;
    logic [CFG_W-1:0] wdata;
    logic [UTC_W-1:0] utc;
    bit               typed;
    local_offset_t    want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  dsto_req_if req_bus ();
  dsto_rsp_if rsp_bus ();
  dsto_cfg_if cfg_bus ();

  dst_utc_offset_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus),
    .cfg_i  (cfg_bus)
  );

  // Shadow copy of the configuration registers, as the block sees them
  logic signed [ZONE_W-1:0] zone_setting;
  dsto_mode_e               mode_setting;

  local_offset_t pending_offsets[$];
  stim_row_t     directed_rows[$];
  int unsigned   error_count;
  int unsigned   cycle_count;
  bit            steady_flow;

  // ---------------------------------------------------------------------
  // Calendar arithmetic on 64-bit signed day and second counts
  // ---------------------------------------------------------------------

  // Floor division and modulo, so that dates before 1970 come out right
  function automatic longint fdiv(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && ((a < 0) != (b < 0))) q--;
    return q;
  endfunction

  function automatic longint fmod(input longint a, input longint b);
    return a - fdiv(a, b) * b;
  endfunction

  // Days since 1970-01-01 of a proleptic Gregorian date
  function automatic longint day_num(input longint y, input longint m, input longint d);
    longint yy, era, yoe, doy, doe;
    yy = (m <= 2) ? y - 1 : y;
    era = fdiv(yy, 400);
    yoe = yy - era * 400;
    doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  // Civil year holding a given day number
  function automatic longint year_of(input longint zd);
    longint z, era, doe, yoe, doy, mp, m;
    z = zd + 719468;
    era = fdiv(z, 146097);
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp = (5 * doy + 2) / 153;
    m = (mp < 10) ? mp + 3 : mp - 9;
    return yoe + era * 400 + ((m <= 2) ? 1 : 0);
  endfunction

  // Sunday is weekday 0; day 0 was a Thursday
  function automatic longint wkday(input longint z);
    return fmod(z + 4, 7);
  endfunction

  function automatic longint sunday_of_month(input longint y, input longint m,
                                             input longint n);
    longint first;
    first = day_num(y, m, 1);
    return first + fmod(7 - wkday(first), 7) + 7 * (n - 1);
  endfunction

  function automatic longint last_sunday31(input longint y, input longint m);
    longint last;
    last = day_num(y, m, 31);
    return last - wkday(last);
  endfunction

  // UTC second at which a rule switches daylight saving on (or off, with
  // is_end set) in year y; the US rule counts in local standard time
  function automatic longint rule_edge(input dsto_mode_e mode, input longint y,
                                       input longint zone, input bit is_end);
    if (mode == DST_US) begin
      if (is_end) return sunday_of_month(y, 11, 1) * 86400 + 3600 - zone;
      return sunday_of_month(y, 3, 2) * 86400 + 7200 - zone;
    end
    if (is_end) return last_sunday31(y, 10) * 86400 + 3600;
    return last_sunday31(y, 3) * 86400 + 3600;
  endfunction

  function automatic bit daylight_applies(input longint utc, input longint zone,
                                          input dsto_mode_e mode);
    longint y;
    case (mode)
      DST_ALWAYS: return 1'b1;
      DST_US: begin
        // Year comes from local standard time
        y = year_of(fdiv(utc + zone, 86400));
        return utc >= rule_edge(DST_US, y, zone, 1'b0) &&
               utc < rule_edge(DST_US, y, zone, 1'b1);
      end
      DST_EU: begin
        y = year_of(fdiv(utc, 86400));
        return utc >= rule_edge(DST_EU, y, zone, 1'b0) &&
               utc < rule_edge(DST_EU, y, zone, 1'b1);
      end
      default: return 1'b0;
    endcase
  endfunction

  // Expected response for one timestamp under the current shadow settings
  function automatic local_offset_t calc_local_offset(input logic [UTC_W-1:0] utc);
    local_offset_t res;
    longint        u, z, off;
    bit            on;
    u = longint'(utc);
    z = longint'(zone_setting);
    on = daylight_applies(u, z, mode_setting);
    off = z + (on ? 3600 : 0);
    // Saturate at the top of the positive range when the DST hour overflows
    if (off > 65535) off = 65535;
    res.offset_seconds = off[ZONE_W-1:0];
    res.dst_on = on;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Clock, reset and the cycle limit
  // ---------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Count cycles; abort when the run hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Response side: random backpressure and the checker
  // ---------------------------------------------------------------------

  // Stall the response channel with a chance of about 29 percent, except
  // during the steady stretch
  always @(negedge clk_i) begin
    rsp_bus.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare each accepted response against the oldest pending offset
  always @(posedge clk_i) begin
    local_offset_t exp_res;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_offsets.size() == 0) begin
        $display("%0t: unexpected response offset_seconds %0d dst_on %0b",
                 $time, rsp_bus.offset_seconds, rsp_bus.dst_on);
        error_count++;
      end else begin
        exp_res = pending_offsets.pop_front();
        if (rsp_bus.offset_seconds !== exp_res.offset_seconds) begin
          $display("%0t: offset_seconds expected %0d actual %0d",
                   $time, exp_res.offset_seconds, rsp_bus.offset_seconds);
          error_count++;
        end
        if (rsp_bus.dst_on !== exp_res.dst_on) begin
          $display("%0t: dst_on expected %0b actual %0b",
                   $time, exp_res.dst_on, rsp_bus.dst_on);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------

  task automatic add_cfg(input dsto_cfg_e sel, input logic [CFG_W-1:0] data);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.reg_sel = sel;
    row.wdata = data;
    row.utc = '0;
    row.typed = 1'b0;
    row.want.offset_seconds = '0;
    row.want.dst_on = 1'b0;
    directed_rows.push_back(row);
  endtask

  // A typed row carries its own expected response; others use the predictor
  task automatic add_req(input longint utc, input bit typed, input int off, input bit dst);
    stim_row_t row;
    row.kind = ROW_REQ;
    row.reg_sel = CFG_ZONE;
    row.wdata = '0;
    row.utc = utc[UTC_W-1:0];
    row.typed = typed;
    row.want.offset_seconds = off[ZONE_W-1:0];
    row.want.dst_on = dst;
    directed_rows.push_back(row);
  endtask

  // Drop valid and hold off until every pending response has come back
  task automatic drain();
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
    while (pending_offsets.size() != 0) @(negedge clk_i);
  endtask

  // Write one register; call only while the pipeline is empty
  task automatic cfg_write(input dsto_cfg_e sel, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.reg_index <= sel;
    cfg_bus.wdata <= data;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    if (sel == CFG_ZONE) zone_setting = signed'(data[ZONE_W-1:0]);
    else mode_setting = dsto_mode_e'(data[1:0]);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // Issue one request, with random gaps ahead of it; valid stays high
  // afterwards so back-to-back requests go at full rate
  task automatic send_utc(input logic [UTC_W-1:0] utc, input bit typed,
                          input local_offset_t want);
    @(negedge clk_i);
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      req_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid <= 1'b1;
    req_bus.utc_seconds <= utc;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    pending_offsets.push_back(typed ? want : calc_local_offset(utc));
  endtask

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  initial begin
    stim_row_t        row;
    local_offset_t    no_want;
    dsto_mode_e       mode_pick;
    dsto_mode_e       edge_mode;
    logic [CFG_W-1:0] zone_pick;
    logic [UTC_W-1:0] utc_pick;
    longint           edge_utc;
    int unsigned      kind_roll;

    // Drive every input to a known value before the first edge
    rst_ni = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.utc_seconds = '0;
    rsp_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.reg_index = CFG_ZONE;
    cfg_bus.wdata = '0;
    zone_setting = '0;
    mode_setting = DST_OFF;
    error_count = 0;
    cycle_count = 0;
    steady_flow = 1'b0;
    no_want.offset_seconds = '0;
    no_want.dst_on = 1'b0;

    // Directed table. Reset state: zone 0, mode off
    add_req(0, 1'b1, 0, 1'b0);
    add_req(32'hFFFF_FFFF, 1'b1, 0, 1'b0);
    // Largest zone with DST always on: the extra hour saturates
    add_cfg(CFG_ZONE, 17'h0FFFF);
    add_cfg(CFG_MODE, CFG_W'(DST_ALWAYS));
    add_req(0, 1'b1, 65535, 1'b1);
    add_req(32'hFFFF_FFFF, 1'b1, 65535, 1'b1);
    // Most negative zone, beyond the usual range
    add_cfg(CFG_ZONE, 17'h10000);
    add_req(12345, 1'b1, -61936, 1'b1);
    add_cfg(CFG_MODE, CFG_W'(DST_OFF));
    add_req(0, 1'b1, -65536, 1'b0);
    add_req(32'h8000_0000, 1'b1, -65536, 1'b0);
    // US rule around the 2024 switch instants, eastern standard time
    add_cfg(CFG_ZONE, CFG_W'(-18000));
    add_cfg(CFG_MODE, CFG_W'(DST_US));
    add_req(rule_edge(DST_US, 2024, -18000, 1'b0) - 1, 1'b0, 0, 1'b0);
    add_req(rule_edge(DST_US, 2024, -18000, 1'b0), 1'b0, 0, 1'b0);
    add_req(rule_edge(DST_US, 2024, -18000, 1'b1) - 1, 1'b0, 0, 1'b0);
    add_req(rule_edge(DST_US, 2024, -18000, 1'b1), 1'b0, 0, 1'b0);
    // Local standard time falls before 1970, then near the top of the 32-bit range
    add_cfg(CFG_ZONE, 17'h10000);
    add_req(0, 1'b0, 0, 1'b0);
    add_req(3600, 1'b0, 0, 1'b0);
    add_req(32'hFFFF_FFFF, 1'b0, 0, 1'b0);
    add_cfg(CFG_ZONE, CFG_W'(50400));
    add_req(rule_edge(DST_US, 2030, 50400, 1'b0), 1'b0, 0, 1'b0);
    add_req(rule_edge(DST_US, 2030, 50400, 1'b1) - 1, 1'b0, 0, 1'b0);
    // EU rule around the 2024 switch instants, in UTC
    add_cfg(CFG_ZONE, CFG_W'(-50400));
    add_cfg(CFG_MODE, CFG_W'(DST_EU));
    add_req(rule_edge(DST_EU, 2024, 0, 1'b0) - 1, 1'b0, 0, 1'b0);
    add_req(rule_edge(DST_EU, 2024, 0, 1'b0), 1'b0, 0, 1'b0);
    add_req(rule_edge(DST_EU, 2024, 0, 1'b1) - 1, 1'b0, 0, 1'b0);
    add_req(rule_edge(DST_EU, 2024, 0, 1'b1), 1'b0, 0, 1'b0);
    add_req(32'hFFFF_FFFF, 1'b0, 0, 1'b0);

    // Hold reset, then release it at a falling edge
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk the table; drain the pipeline ahead of each register write
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        drain();
        cfg_write(row.reg_sel, row.wdata);
      end else begin
        send_utc(row.utc, row.typed, row.want);
      end
    end

    // Random phases: each first drains, then picks a mode and a zone.
    // The first four phases walk all modes; the rest alternate the two rules.
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      if (phase < 4) mode_pick = dsto_mode_e'(phase);
      else mode_pick = (phase % 2 != 0) ? DST_EU : DST_US;
      case ($urandom_range(9))
        0: zone_pick = 17'h0FFFF;
        1: zone_pick = 17'h10000;
        2: zone_pick = CFG_W'($urandom);
        default: zone_pick = CFG_W'(int'($urandom_range(100800)) - 50400);
      endcase
      cfg_write(CFG_ZONE, zone_pick);
      cfg_write(CFG_MODE, CFG_W'(mode_pick));
      // One phase runs with no idling on either side
      steady_flow = (phase == 3);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Pause once mid-phase until the pipeline has emptied
        if (phase == 5 && n == 40) drain();
        kind_roll = $urandom_range(9);
        if (kind_roll < 4) begin
          utc_pick = $urandom;
        end else if (kind_roll < 8) begin
          // Land close to a switch instant of a random year
          if (mode_setting == DST_US || mode_setting == DST_EU) edge_mode = mode_setting;
          else edge_mode = ($urandom_range(1) != 0) ? DST_US : DST_EU;
          edge_utc = rule_edge(edge_mode, longint'($urandom_range(2105, 1970)),
                               longint'(zone_setting), 1'($urandom_range(1)));
          if ($urandom_range(1) != 0) edge_utc += longint'($urandom_range(4)) - 2;
          else edge_utc += longint'($urandom_range(14400)) - 7200;
          if (edge_utc < 0) edge_utc = 0;
          if (edge_utc > 64'hFFFF_FFFF) edge_utc = 64'hFFFF_FFFF;
          utc_pick = edge_utc[UTC_W-1:0];
        end else if (kind_roll == 8) begin
          utc_pick = $urandom_range(200000);
        end else begin
          utc_pick = 32'hFFFF_FFFF - $urandom_range(200000);
        end
        send_utc(utc_pick, 1'b0, no_want);
      end
    end

    // Wait out the pipeline, then watch for stray responses
    steady_flow = 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (error_count == 0 && pending_offsets.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
